// ----- hw/rtl/gfpu_pkg.sv -----
// Shared types, constants and the compass key function of the GPS frame parser.
package gfpu_pkg;

   // Field widths
   localparam int BYTE_W = 8;
   localparam int OFFSET_W = 6;
   localparam int LENGTH_W = 6;

   // Frame bytes
   localparam logic [BYTE_W-1:0] SYNC_FIRST = 8'h55;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;
   localparam logic [BYTE_W-1:0] ID_GPS = 8'h10;
   localparam logic [BYTE_W-1:0] ID_COMPASS = 8'h20;
   localparam logic [BYTE_W-1:0] LEN_GPS = 8'd58;
   localparam logic [BYTE_W-1:0] LEN_COMPASS = 8'd6;

   // Message kinds
   localparam logic KIND_GPS = 1'b0;
   localparam logic KIND_COMPASS = 1'b1;

   // Payload offsets with special treatment
   localparam int GPS_KEY_OFFSET = 55;
   localparam logic [OFFSET_W-1:0] GPS_KEEP_A = 6'd48;
   localparam logic [OFFSET_W-1:0] GPS_KEEP_B = 6'd49;
   localparam logic [OFFSET_W-1:0] GPS_KEEP_C = 6'd56;
   localparam logic [OFFSET_W-1:0] GPS_KEEP_D = 6'd57;
   localparam logic [OFFSET_W-1:0] COMPASS_KEY_OFFSET = 6'd4;

   // Frame start request from the parser to the emitter
   typedef struct packed {
      logic                start;
      logic                kind;
      logic [LENGTH_W-1:0] length;
   } gfpu_start_type;

   // Derive the compass XOR mask from its key byte
   function automatic logic [BYTE_W-1:0] compass_mask(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      logic [BYTE_W-1:0] fix;
      lo = (b ^ (b >> 4)) & 8'h0F;
      hi = (b << 3) & 8'hF0;
      fix = {b[0], 3'b000, b[0], 3'b000};
      return (lo | hi) ^ fix;
   endfunction

endpackage

// ----- hw/rtl/gfpu_if.sv -----
// Valid/ready channel interfaces for received bytes and decoded payload bytes.
interface gfpu_req_if;
   import gfpu_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface gfpu_rsp_if;
   import gfpu_pkg::*;
   logic                valid;
   logic                ready;
   logic                msg_kind;
   logic [OFFSET_W-1:0] byte_offset;
   logic [BYTE_W-1:0]   plain_byte;
   logic                last_byte;
   modport source (output valid, output msg_kind, output byte_offset, output plain_byte,
                   output last_byte, input ready);
   modport sink (input valid, input msg_kind, input byte_offset, input plain_byte,
                 input last_byte, output ready);
endinterface

// ----- hw/rtl/gps_frame_parser_unmask_top.sv -----
// Top level of the GPS/compass frame parser with payload unmasking.
//
// Channels: req_chan carries one received serial byte per transfer (rx_byte);
// rsp_chan carries one decoded payload byte per transfer (msg_kind,
// byte_offset, plain_byte, last_byte). Both use valid/ready handshakes.
// Every received byte is taken while req_chan.ready is high and produces no output,
// except the second checksum byte of a frame whose header and checksum are
// good. That byte starts the emitter: it fetches the key byte from the
// payload RAM (E_KEY_READ, E_KEY_TAKE), then for each payload byte does one RAM
// read (E_READ) and one load of the output register (E_LOAD), for the 58 bytes
// of a GPS frame or the 6 of a compass frame. The single read port of the
// payload RAM paces the emitter. req_chan.ready is low while the emitter
// runs and returns high once the last byte is in the output register.
// Reset returns the parser to the sync hunt and empties the output register;
// the payload RAM is not cleared. When the receiver stalls, the current
// output byte holds and the emitter waits with the next byte in RAM read data.
module gps_frame_parser_unmask_top #(
   parameter int MAX_PAYLOAD = 58
) (
   input  logic       clock,
   input  logic       reset,
   gfpu_req_if.sink   req_chan,
   gfpu_rsp_if.source rsp_chan
);
   import gfpu_pkg::*;

   localparam int AW = $clog2(MAX_PAYLOAD);

   gfpu_start_type    start;
   logic              busy;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [BYTE_W-1:0] rd_data;

   gfpu_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .busy     (busy),
      .start    (start),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   gfpu_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PAYLOAD)) u_payload_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gfpu_emitter #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_emitter (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .rsp_chan (rsp_chan),
      .busy     (busy)
   );

   // A frame start comes only from an accepted byte
   a_start_on_transfer: assert property (@(posedge clock) disable iff (reset)
      start.start |-> (req_chan.valid && req_chan.ready))
      else $error("frame start without an input transfer");

   // The emitter takes up every frame start
   a_start_taken: assert property (@(posedge clock) disable iff (reset)
      start.start |=> busy)
      else $error("frame start not taken by the emitter");

   // The payload RAM is never written while the emitter reads it
   a_no_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr_en)
      else $error("payload write during emission");

   // The final byte sits at the end of a frame of the right kind
   a_last_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.last_byte) |->
         ((rsp_chan.msg_kind == KIND_GPS && rsp_chan.byte_offset == GPS_KEEP_D) ||
          (rsp_chan.msg_kind == KIND_COMPASS && rsp_chan.byte_offset == 6'd5)))
      else $error("last byte at an unexpected offset");
endmodule

// ----- hw/rtl/gfpu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gfpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 58
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/gfpu_parser.sv -----
// Byte-level frame parser: sync hunt, header check, payload store and checksum.
module gfpu_parser #(
   parameter int MAX_PAYLOAD = 58
) (
   input  logic                           clock,
   input  logic                           reset,
   gfpu_req_if.sink                       req_chan,
   input  logic                           busy,
   output gfpu_pkg::gfpu_start_type       start,
   output logic                           wr_en,
   output logic [$clog2(MAX_PAYLOAD)-1:0] wr_addr,
   output logic [7:0]                     wr_data
);
   import gfpu_pkg::*;

   localparam int AW = $clog2(MAX_PAYLOAD);
   localparam logic [LENGTH_W:0] CountLimit = (LENGTH_W+1)'(MAX_PAYLOAD);

   // Parser phases
   localparam logic [2:0] PH_SYNC1 = 3'd0;
   localparam logic [2:0] PH_SYNC2 = 3'd1;
   localparam logic [2:0] PH_ID    = 3'd2;
   localparam logic [2:0] PH_LEN   = 3'd3;
   localparam logic [2:0] PH_SKIP  = 3'd4;
   localparam logic [2:0] PH_DATA  = 3'd5;
   localparam logic [2:0] PH_CK1   = 3'd6;
   localparam logic [2:0] PH_CK2   = 3'd7;

   logic [2:0]          phase_ff, phase_in;
   logic                kind_ff, kind_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic [LENGTH_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0]   sum_lo_ff, sum_lo_in;
   logic [BYTE_W-1:0]   sum_hi_ff, sum_hi_in;
   logic [BYTE_W-1:0]   b;
   logic [BYTE_W-1:0]   sum_lo_add;
   logic [BYTE_W-1:0]   sum_hi_add;
   logic                accept;

   assign req_chan.ready = !busy;
   assign accept = req_chan.valid && req_chan.ready;
   assign b = req_chan.rx_byte;

   // Running sums with the current byte folded in
   assign sum_lo_add = sum_lo_ff + b;
   assign sum_hi_add = sum_hi_ff + sum_lo_add;

   // Advance the parser on each transfer
   always_comb begin
      phase_in = phase_ff;
      kind_in = kind_ff;
      length_in = length_ff;
      count_in = count_ff;
      sum_lo_in = sum_lo_ff;
      sum_hi_in = sum_hi_ff;
      start.start = 1'b0;
      start.kind = kind_ff;
      start.length = length_ff;
      wr_en = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = b;
      if (accept) begin
         case (phase_ff)
            PH_SYNC1: begin
               if (b == SYNC_FIRST) phase_in = PH_SYNC2;
            end
            PH_SYNC2: begin
               if (b == SYNC_SECOND) begin
                  sum_lo_in = '0;
                  sum_hi_in = '0;
                  phase_in = PH_ID;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_ID: begin
               sum_lo_in = sum_lo_add;
               sum_hi_in = sum_hi_add;
               if (b == ID_GPS) begin
                  kind_in = KIND_GPS;
                  phase_in = PH_LEN;
               end else if (b == ID_COMPASS) begin
                  kind_in = KIND_COMPASS;
                  phase_in = PH_LEN;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_LEN: begin
               if ((kind_ff == KIND_GPS && b == LEN_GPS) ||
                   (kind_ff == KIND_COMPASS && b == LEN_COMPASS)) begin
                  length_in = b[LENGTH_W-1:0];
                  count_in = '0;
                  sum_lo_in = sum_lo_add;
                  sum_hi_in = sum_hi_add;
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_SKIP: begin
               phase_in = PH_SYNC1;
            end
            PH_DATA: begin
               wr_en = {1'b0, count_ff} < CountLimit;
               count_in = count_ff + 1'b1;
               sum_lo_in = sum_lo_add;
               sum_hi_in = sum_hi_add;
               if (count_in >= length_ff) phase_in = PH_CK1;
            end
            PH_CK1: begin
               phase_in = (b == sum_lo_ff) ? PH_CK2 : PH_SYNC1;
            end
            default: begin
               // Second checksum byte: hand a good frame to the emitter
               start.start = (b == sum_hi_ff);
               phase_in = PH_SYNC1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         kind_ff <= 1'b0;
         length_ff <= '0;
         count_ff <= '0;
         sum_lo_ff <= '0;
         sum_hi_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         kind_ff <= kind_in;
         length_ff <= length_in;
         count_ff <= count_in;
         sum_lo_ff <= sum_lo_in;
         sum_hi_ff <= sum_hi_in;
      end
   end
endmodule

// ----- hw/rtl/gfpu_emitter.sv -----
// Payload emitter: fetches the key byte, then reads each byte, unmasks it unless it is kept, and sends it.
module gfpu_emitter #(
   parameter int MAX_PAYLOAD = 58
) (
   input  logic                           clock,
   input  logic                           reset,
   input  gfpu_pkg::gfpu_start_type       start,
   output logic                           rd_en,
   output logic [$clog2(MAX_PAYLOAD)-1:0] rd_addr,
   input  logic [7:0]                     rd_data,
   gfpu_rsp_if.source                     rsp_chan,
   output logic                           busy
);
   import gfpu_pkg::*;

   localparam int AW = $clog2(MAX_PAYLOAD);
   localparam logic [AW-1:0] GpsKeyAddr = AW'(GPS_KEY_OFFSET % MAX_PAYLOAD);
   localparam logic [AW-1:0] CompassKeyAddr = COMPASS_KEY_OFFSET[AW-1:0];

   // Sequencer states
   localparam logic [2:0] E_IDLE     = 3'd0;
   localparam logic [2:0] E_KEY_READ = 3'd1;
   localparam logic [2:0] E_KEY_TAKE = 3'd2;
   localparam logic [2:0] E_READ     = 3'd3;
   localparam logic [2:0] E_LOAD     = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic                kind_ff, kind_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic [OFFSET_W-1:0] idx_ff, idx_in;
   logic [BYTE_W-1:0]   mask_ff, mask_in;
   logic                valid_ff, valid_in;
   logic                kind_out_ff, kind_out_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [BYTE_W-1:0]   plain_ff, plain_in;
   logic                last_ff, last_in;
   logic                keep;
   logic                is_last;
   logic                out_free;

   // Bytes that pass without unmasking
   always_comb begin
      if (kind_ff == KIND_GPS) begin
         keep = idx_ff inside {GPS_KEEP_A, GPS_KEEP_B, GPS_KEEP_C, GPS_KEEP_D};
      end else begin
         keep = (idx_ff == COMPASS_KEY_OFFSET);
      end
   end

   assign is_last = (idx_ff == length_ff - 1'b1);
   assign out_free = !valid_ff || rsp_chan.ready;

   // Sequence the key fetch and the per-byte read/unmask loop
   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      length_in = length_ff;
      idx_in = idx_ff;
      mask_in = mask_ff;
      valid_in = valid_ff && !rsp_chan.ready;
      kind_out_in = kind_out_ff;
      offset_in = offset_ff;
      plain_in = plain_ff;
      last_in = last_ff;
      rd_en = 1'b0;
      rd_addr = idx_ff[AW-1:0];
      case (state_ff)
         E_IDLE: begin
            if (start.start) begin
               kind_in = start.kind;
               length_in = start.length;
               state_in = E_KEY_READ;
            end
         end
         E_KEY_READ: begin
            rd_en = 1'b1;
            rd_addr = (kind_ff == KIND_GPS) ? GpsKeyAddr : CompassKeyAddr;
            state_in = E_KEY_TAKE;
         end
         E_KEY_TAKE: begin
            mask_in = (kind_ff == KIND_GPS) ? rd_data : compass_mask(rd_data);
            idx_in = '0;
            state_in = E_READ;
         end
         E_READ: begin
            rd_en = 1'b1;
            state_in = E_LOAD;
         end
         E_LOAD: begin
            // Hold the read data until the output register frees up
            if (out_free) begin
               valid_in = 1'b1;
               kind_out_in = kind_ff;
               offset_in = idx_ff;
               plain_in = keep ? rd_data : (rd_data ^ mask_ff);
               last_in = is_last;
               if (is_last) begin
                  state_in = E_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = E_READ;
               end
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      length_ff <= length_in;
      idx_ff <= idx_in;
      mask_ff <= mask_in;
      kind_out_ff <= kind_out_in;
      offset_ff <= offset_in;
      plain_ff <= plain_in;
      last_ff <= last_in;
   end

   assign busy = (state_ff != E_IDLE);
   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.msg_kind = kind_out_ff;
   assign rsp_chan.byte_offset = offset_ff;
   assign rsp_chan.plain_byte = plain_ff;
   assign rsp_chan.last_byte = last_ff;
endmodule
